// ----- hw/rtl/ppa_pkg.sv -----
// Shared types and constants for the polygon perimeter / area block.
// Used by ppa_mul, ppa_isqrt and polygon_perimeter_area. No dependencies.
`timescale 1ns / 1ps

package ppa_pkg;

	// coordinate and item geometry
	localparam int COORD_W      = 16;
	localparam int DIFF_W       = COORD_W + 1;
	localparam int TERM_W       = 2 * COORD_W;
	localparam int SQ_W         = 2 * COORD_W + 1;
	localparam int FRAC_B       = 8;
	localparam int MAX_VERTICES = 256;
	localparam int CNT_W        = $clog2(MAX_VERTICES + 1);

	// accumulators
	localparam int LEN_W   = 34;
	localparam int SIDE_W  = 26;
	localparam int CROSS_W = 41;
	localparam int AREA_W  = 40;
	localparam int CRS_W   = CROSS_W + 2;

	// square root: radicand is the squared length shifted up by 2*FRAC_B, padded to even
	localparam int ROOT_W = (SQ_W + 2 * FRAC_B + 1) / 2;
	localparam int RAD_W  = 2 * ROOT_W;
	localparam int REM_W  = ROOT_W + 3;
	localparam int ITER_W = $clog2(ROOT_W + 1);

	// shared multiplier
	localparam int MUL_A_W = (SIDE_W + 1 > DIFF_W) ? SIDE_W + 1 : DIFF_W;
	localparam int MUL_B_W = (CNT_W + 1 > DIFF_W + 1) ? CNT_W + 1 : DIFF_W + 1;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	// stream packing
	localparam int S_DATA_W = 2 * COORD_W;
	localparam int M_RAW_W  = LEN_W + AREA_W + CNT_W;
	localparam int M_DATA_W = ((M_RAW_W + 7) / 8) * 8;

	// perimeter modes
	localparam logic [1:0] MODE_OPEN    = 2'd0;
	localparam logic [1:0] MODE_CLOSED  = 2'd1;
	localparam logic [1:0] MODE_REGULAR = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQX,
		ST_SQY,
		ST_RGO,
		ST_CRA,
		ST_CRB,
		ST_CRC,
		ST_WAIT,
		ST_POST,
		ST_MODE,
		ST_RMUL,
		ST_OUT
	} st_t;

	typedef struct packed {
		logic             start;
		logic [RAD_W-1:0] radicand;
	} isq_req_t;

	typedef struct packed {
		logic              busy;
		logic              done;
		logic [ROOT_W-1:0] root;
	} isq_rsp_t;

endpackage

// ----- hw/rtl/ppa_mul.sv -----
// Shared signed multiplier with registered product.
// Depends on ppa_pkg for operand widths.
`timescale 1ns / 1ps

module ppa_mul (
	input  logic                                clk,
	input  logic signed [ppa_pkg::MUL_A_W-1:0]  a,
	input  logic signed [ppa_pkg::MUL_B_W-1:0]  b,
	output logic signed [ppa_pkg::MUL_P_W-1:0]  p
);
	import ppa_pkg::*;

	logic signed [MUL_P_W-1:0] p_q;

	always_ff @(posedge clk) begin
		p_q <= a * b;
	end

	assign p = p_q;

endmodule

// ----- hw/rtl/ppa_isqrt.sv -----
// Bit-serial integer square root, one root bit per cycle (restoring).
// Depends on ppa_pkg for widths and the request/response structs.
`timescale 1ns / 1ps

module ppa_isqrt (
	input  logic              clk,
	input  logic              arst_n,
	input  ppa_pkg::isq_req_t req,
	output ppa_pkg::isq_rsp_t rsp
);
	import ppa_pkg::*;

	logic [RAD_W-1:0]  rad_q;
	logic [REM_W-1:0]  rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [ITER_W-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;

	logic [REM_W-1:0] rem_sh;
	logic [REM_W-1:0] trial;
	logic             take;

	always_comb begin
		rem_sh = {rem_q[REM_W-3:0], rad_q[RAD_W-1 -: 2]};
		trial  = {{(REM_W-ROOT_W-2){1'b0}}, root_q, 2'b01};
		take   = (rem_sh >= trial);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= ITER_W'(ROOT_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == ITER_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rad_q  <= req.radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q <= {rad_q[RAD_W-3:0], 2'b00};
			if (take) begin
				rem_q  <= rem_sh - trial;
				root_q <= {root_q[ROOT_W-2:0], 1'b1};
			end else begin
				rem_q  <= rem_sh;
				root_q <= {root_q[ROOT_W-2:0], 1'b0};
			end
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.root = root_q;

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !busy_q)
		else $error("isqrt restarted while busy");

	a_finish: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && !req.start && cnt_q == ITER_W'(1)) |=> (done_q && !busy_q))
		else $error("isqrt did not finish after last iteration");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("isqrt done held longer than one cycle");

endmodule

// ----- hw/rtl/polygon_perimeter_area.sv -----
// Polygon perimeter and shoelace area, top level: stream ports, sequencer, accumulators.
// Depends on ppa_pkg, ppa_mul and ppa_isqrt.
`timescale 1ns / 1ps

// Usage
//  Slave stream: one vertex per item, s_tdata = {vertex_y, vertex_x} (x in the low bits),
//  s_tlast marks the final vertex of a polygon. Items are taken only while the sequencer
//  is idle (s_tready high).
//  Master stream: one item per polygon, emitted after the last vertex. m_tdata holds
//  perimeter (Q.8), twice_area and vertex_count; m_tuser is the overflow flag.
//  Config: cfg_valid/cfg_data write perimeter_mode (0 open, 1 closed, 2 regular,
//  3 treated as open); cfg_ready is always high. Write only while the block is idle.
// Processing
//  Every vertex after the first runs one segment through the shared multiplier
//  (dx^2, dy^2, two cross terms) and the bit-serial square root, 25 iterations,
//  and waits for the root before the next vertex is taken. The first vertex skips this.
//  On the last vertex closed mode runs the closing segment the same way; open and regular
//  modes run only the closing cross terms, and regular mode takes first side * count.
// Reset and stall
//  arst_n clears the polygon state and sets the mode to closed. A result waits in
//  the output register; the next polygon's vertices are still taken, and only its
//  own result waits for the register to drain.

module polygon_perimeter_area (
	input  logic                            clk,
	input  logic                            arst_n,
	// slave stream
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [ppa_pkg::S_DATA_W-1:0]    s_tdata,   // vertex_x, vertex_y
	input  logic                            s_tlast,   // is_last
	// master stream
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [ppa_pkg::M_DATA_W-1:0]    m_tdata,   // perimeter, twice_area, vertex_count
	output logic                            m_tuser,   // overflow
	// config write
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [1:0]                      cfg_data   // perimeter_mode
);
	import ppa_pkg::*;

	st_t state_q, state_d;

	logic [1:0] mode_q;

	// current item and polygon state
	logic signed [COORD_W-1:0] x_q, y_q;
	logic                      last_q;
	logic                      fin_q;      // working on the closing terms
	logic signed [COORD_W-1:0] first_x_q, first_y_q;
	logic signed [COORD_W-1:0] prev_x_q, prev_y_q;
	logic [LEN_W-1:0]          length_q;
	logic [SIDE_W-1:0]         side_q;
	logic signed [CROSS_W-1:0] cross_q;
	logic [CNT_W-1:0]          count_q;
	logic                      sat_q;

	// scratch
	logic [SQ_W-1:0]          sq_q;
	logic signed [TERM_W-1:0] term_q;
	logic [LEN_W-1:0]         per_q;

	// output register
	logic                m_tvalid_q;
	logic [LEN_W-1:0]    out_per_q;
	logic [AREA_W-1:0]   out_area_q;
	logic [CNT_W-1:0]    out_cnt_q;
	logic                out_ovf_q;

	// shared units
	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [MUL_P_W-1:0] mul_p;
	isq_req_t                  isq_req;
	isq_rsp_t                  isq_rsp;

	// segment endpoints: A->B is prev->cur, or cur->first on the closing pass
	logic signed [COORD_W-1:0] ax, ay, bx, by;
	logic signed [DIFF_W-1:0]  dx, dy;

	logic                      in_acc;
	logic                      out_load;
	logic [SQ_W-1:0]           sq_sum;
	logic signed [CRS_W-1:0]   cr_sum;
	logic                      cr_fit;
	logic signed [CROSS_W-1:0] cr_clamp;
	logic [LEN_W:0]            len_sum;
	logic [CROSS_W-1:0]        area_mag;
	logic                      area_sat;
	logic [AREA_W-1:0]         area_val;

	assign in_acc    = s_tvalid && s_tready;
	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign out_load  = (state_q == ST_OUT) && (!m_tvalid_q || m_tready);

	always_comb begin
		ax = fin_q ? x_q : prev_x_q;
		ay = fin_q ? y_q : prev_y_q;
		bx = fin_q ? first_x_q : x_q;
		by = fin_q ? first_y_q : y_q;
		dx = {bx[COORD_W-1], bx} - {ax[COORD_W-1], ax};
		dy = {by[COORD_W-1], by} - {ay[COORD_W-1], ay};

		sq_sum = sq_q + mul_p[SQ_W-1:0];

		// cross_sum + (Ax*By - Bx*Ay), clamped to the signed 41-bit range
		cr_sum = CRS_W'(cross_q) + CRS_W'(term_q) - CRS_W'($signed(mul_p[TERM_W-1:0]));
		cr_fit = (cr_sum[CRS_W-1:CROSS_W-1] == '0) || (cr_sum[CRS_W-1:CROSS_W-1] == '1);
		if (cr_fit) begin
			cr_clamp = cr_sum[CROSS_W-1:0];
		end else if (cr_sum[CRS_W-1]) begin
			cr_clamp = {1'b1, {(CROSS_W-1){1'b0}}};
		end else begin
			cr_clamp = {1'b0, {(CROSS_W-1){1'b1}}};
		end

		len_sum = {1'b0, length_q} + (LEN_W+1)'(isq_rsp.root);

		// |cross| fits 40 bits except for the most negative value
		area_mag = cross_q[CROSS_W-1] ? (~cross_q + 1'b1) : cross_q;
		area_sat = area_mag[CROSS_W-1];
		area_val = area_sat ? {AREA_W{1'b1}} : area_mag[AREA_W-1:0];
	end

	// next state, multiplier operands, square root launch
	always_comb begin
		state_d          = state_q;
		mul_a            = '0;
		mul_b            = '0;
		isq_req.start    = 1'b0;
		isq_req.radicand = {1'b0, sq_sum, {(2*FRAC_B){1'b0}}};
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					state_d = (count_q == '0) ? ST_POST : ST_SQX;
				end
			end
			ST_SQX: begin
				mul_a   = MUL_A_W'(dx);
				mul_b   = MUL_B_W'(dx);
				state_d = ST_SQY;
			end
			ST_SQY: begin
				mul_a   = MUL_A_W'(dy);
				mul_b   = MUL_B_W'(dy);
				state_d = ST_RGO;
			end
			ST_RGO: begin
				isq_req.start = 1'b1;
				state_d       = ST_CRA;
			end
			ST_CRA: begin
				mul_a   = MUL_A_W'(ax);
				mul_b   = MUL_B_W'(by);
				state_d = ST_CRB;
			end
			ST_CRB: begin
				mul_a   = MUL_A_W'(bx);
				mul_b   = MUL_B_W'(ay);
				state_d = ST_CRC;
			end
			ST_CRC: begin
				state_d = (fin_q && mode_q != MODE_CLOSED) ? ST_MODE : ST_WAIT;
			end
			ST_WAIT: begin
				if (isq_rsp.done) begin
					state_d = fin_q ? ST_OUT : ST_POST;
				end
			end
			ST_POST: begin
				if (!last_q) begin
					state_d = ST_IDLE;
				end else if (mode_q == MODE_CLOSED) begin
					state_d = ST_SQX;
				end else begin
					state_d = ST_CRA;
				end
			end
			ST_MODE: begin
				mul_a   = MUL_A_W'({1'b0, side_q});
				mul_b   = MUL_B_W'({1'b0, count_q});
				state_d = (mode_q == MODE_REGULAR) ? ST_RMUL : ST_OUT;
			end
			ST_RMUL: begin
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_CLOSED;
		end else if (cfg_valid && cfg_ready) begin
			mode_q <= cfg_data;
		end
	end

	// polygon accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_q    <= 1'b0;
			length_q <= '0;
			side_q   <= '0;
			cross_q  <= '0;
			count_q  <= '0;
			sat_q    <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						fin_q <= 1'b0;
					end
				end
				ST_CRC: begin
					cross_q <= cr_clamp;
					if (!cr_fit) begin
						sat_q <= 1'b1;
					end
				end
				ST_WAIT: begin
					if (isq_rsp.done && !fin_q) begin
						if (len_sum[LEN_W]) begin
							length_q <= {LEN_W{1'b1}};
							sat_q    <= 1'b1;
						end else begin
							length_q <= len_sum[LEN_W-1:0];
						end
						if (count_q == CNT_W'(1)) begin
							side_q <= SIDE_W'(isq_rsp.root);
						end
					end else if (isq_rsp.done && len_sum[LEN_W]) begin
						sat_q <= 1'b1;
					end
				end
				ST_POST: begin
					if (count_q < CNT_W'(MAX_VERTICES)) begin
						count_q <= count_q + 1'b1;
					end else begin
						sat_q <= 1'b1;
					end
					if (last_q) begin
						fin_q <= 1'b1;
					end
				end
				ST_RMUL: begin
					if (mul_p[MUL_P_W-1:LEN_W] != '0) begin
						sat_q <= 1'b1;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						fin_q    <= 1'b0;
						length_q <= '0;
						side_q   <= '0;
						cross_q  <= '0;
						count_q  <= '0;
						sat_q    <= 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// vertex registers and scratch (payload)
	always_ff @(posedge clk) begin
		if (in_acc) begin
			x_q    <= s_tdata[COORD_W-1:0];
			y_q    <= s_tdata[2*COORD_W-1:COORD_W];
			last_q <= s_tlast;
			if (count_q == '0) begin
				first_x_q <= s_tdata[COORD_W-1:0];
				first_y_q <= s_tdata[2*COORD_W-1:COORD_W];
			end
		end
		if (state_q == ST_SQY) begin
			sq_q <= mul_p[SQ_W-1:0];
		end
		if (state_q == ST_CRB) begin
			term_q <= mul_p[TERM_W-1:0];
		end
		if (state_q == ST_POST) begin
			prev_x_q <= x_q;
			prev_y_q <= y_q;
		end
		// final perimeter by mode
		if (state_q == ST_WAIT && fin_q && isq_rsp.done) begin
			per_q <= len_sum[LEN_W] ? {LEN_W{1'b1}} : len_sum[LEN_W-1:0];
		end
		if (state_q == ST_MODE) begin
			per_q <= length_q;
		end
		if (state_q == ST_RMUL) begin
			per_q <= (mul_p[MUL_P_W-1:LEN_W] != '0) ? {LEN_W{1'b1}} : mul_p[LEN_W-1:0];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_per_q  <= per_q;
			out_area_q <= area_val;
			out_cnt_q  <= count_q;
			out_ovf_q  <= sat_q || area_sat;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(M_DATA_W-M_RAW_W){1'b0}}, out_cnt_q, out_area_q, out_per_q};
	assign m_tuser  = out_ovf_q;

	ppa_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (mul_p)
	);

	ppa_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (isq_req),
		.rsp    (isq_rsp)
	);

	a_wait_live: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WAIT) |-> (isq_rsp.busy || isq_rsp.done))
		else $error("waiting on square root that is not running");

	a_clear_after_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (count_q == '0 && !sat_q && !fin_q))
		else $error("polygon state not cleared after result");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_VERTICES))
		else $error("vertex count beyond limit");

	a_result_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (count_q != '0))
		else $error("result issued for an empty polygon");

endmodule
